// ===== sv/lsfb_pkg.sv =====
// Shared types, codes and the gamma table for the LED strip frame buffer.
// No dependencies; every other file in this block imports it.
`timescale 1ns / 1ps
`default_nettype none

package lsfb_pkg;

  localparam int NUM_LEDS_DEF = 32;

  // Field widths fixed by the item format
  localparam int IDX_W   = 6;
  localparam int OP_W    = 2;
  localparam int ORD_W   = 2;
  localparam int CFG_W   = 6;
  localparam int CFGI_W  = 1;
  localparam int WORD_W  = 24;

  // Operation codes
  localparam logic [OP_W-1:0] OP_SET     = 2'd0;
  localparam logic [OP_W-1:0] OP_FILL    = 2'd1;
  localparam logic [OP_W-1:0] OP_REFRESH = 2'd2;

  // Configuration register indexes
  localparam logic [CFGI_W-1:0] CFG_LED_COUNT     = 1'b0;
  localparam logic [CFGI_W-1:0] CFG_CHANNEL_ORDER = 1'b1;

  // Channel order codes (3 behaves as BRG)
  localparam logic [ORD_W-1:0] ORDER_RGB = 2'd0;
  localparam logic [ORD_W-1:0] ORDER_GRB = 2'd1;
  localparam logic [ORD_W-1:0] ORDER_BRG = 2'd2;

  localparam logic [IDX_W-1:0] LED_COUNT_RST = 6'd32;

  localparam logic [2:0] BYTES_LED   = 3'd3;
  localparam logic [2:0] BYTES_LATCH = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] last_index;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte0;
    logic [7:0] out_byte1;
    logic [7:0] out_byte2;
    logic [7:0] out_byte3;
    logic [2:0] byte_count;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_READ,
    ST_LATCH
  } lsfb_state_t;

  typedef logic [7:0] gamma_rom_t [256];

  // 0x80 | round(127 * (x/255)^2.5), in exact integers; elaboration only.
  function automatic gamma_rom_t gamma_init();
    gamma_rom_t        rom;
    longint unsigned   x5;
    longint unsigned   lhs;
    longint unsigned   full;
    longint unsigned   odd;
    int unsigned       v;
    bit                run;
    full = 64'd255 * 64'd255 * 64'd255 * 64'd255 * 64'd255;
    for (int x = 0; x < 256; x++) begin
      x5  = longint'(x) * x * x * x * x;
      lhs = 64'd64516 * x5;
      v   = 0;
      run = 1'b1;
      for (int k = 1; k <= 127; k++) begin
        odd = 64'(2 * k - 1);
        if (run && lhs >= odd * odd * full) v = k;
        else run = 1'b0;
      end
      rom[x] = 8'h80 | 8'(v);
    end
    return rom;
  endfunction

  localparam gamma_rom_t GAMMA_ROM = gamma_init();

  // Stored word: byte0 in [23:16], byte1 in [15:8], byte2 in [7:0].
  function automatic logic [WORD_W-1:0] order_word(input logic [7:0] r,
                                                   input logic [7:0] g,
                                                   input logic [7:0] b,
                                                   input logic [ORD_W-1:0] ord);
    logic [WORD_W-1:0] w;
    case (ord)
      ORDER_RGB: w = {r, g, b};
      ORDER_GRB: w = {g, r, b};
      default:   w = {b, r, g};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== sv/led_strip_frame_buffer.sv =====
// Top level of the LED strip frame buffer: command sequencer and config.
// Depends on lsfb_pkg and lsfb_mem.
`timescale 1ns / 1ps
`default_nettype none

// A command is taken when start is high and busy is low. A set command
// writes its gamma-corrected pixel in the transfer cycle itself and leaves
// busy low. A fill walks its range, one pixel per cycle, with busy high
// throughout. A refresh reads the pixel store one LED per cycle; each chunk
// appears on out_data for a single cycle with out_strobe high, in the cycle
// after its read is issued, and the four-byte zero latch chunk (last = 1)
// follows the final LED chunk in the next cycle. A refresh of N LEDs holds
// busy through its reads and latch and emits N + 1 transfers; the pace is
// set by the single read port of the pixel store. There is no backpressure:
// the receiver must take every strobed transfer. Pixels must be written
// before they are refreshed; an unwritten pixel reads as garbage.
// Configuration writes apply at once and belong in idle periods.

module led_strip_frame_buffer #(
  parameter int NUM_LEDS = lsfb_pkg::NUM_LEDS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire lsfb_pkg::in_item_t          in_data,
  output logic                             out_strobe,
  output lsfb_pkg::out_item_t              out_data,
  input  wire logic                        cfg_we,
  input  wire logic [lsfb_pkg::CFGI_W-1:0] cfg_index,
  input  wire logic [lsfb_pkg::CFG_W-1:0]  cfg_data
);
  import lsfb_pkg::*;

  localparam int ADDR_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam logic [IDX_W-1:0] NUM_LEDS_V = IDX_W'(NUM_LEDS);

  // Config registers
  logic [IDX_W-1:0] led_count_r;
  logic [ORD_W-1:0] order_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_count_r <= LED_COUNT_RST;
      order_r     <= ORDER_BRG;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LED_COUNT:     led_count_r <= cfg_data;
        CFG_CHANNEL_ORDER: order_r     <= cfg_data[ORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Command decode
  logic              accept;
  logic [IDX_W-1:0]  eff_count;
  logic [IDX_W-1:0]  fill_end;
  logic              fill_go;
  logic              set_ok;
  logic [WORD_W-1:0] in_word;

  assign accept    = start && !busy;
  assign eff_count = (led_count_r < NUM_LEDS_V) ? led_count_r : NUM_LEDS_V;
  // end of 0 or past the last LED clamps to the last LED
  assign fill_end  = (in_data.last_index == '0 || in_data.last_index > eff_count - 1'b1)
                     ? eff_count - 1'b1 : in_data.last_index;
  assign fill_go   = (eff_count != '0) && (in_data.first_index <= fill_end);
  assign set_ok    = in_data.first_index < eff_count;
  assign in_word   = order_word(GAMMA_ROM[in_data.red], GAMMA_ROM[in_data.green],
                                GAMMA_ROM[in_data.blue], order_r);

  // Sequencer
  lsfb_state_t       state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  end_r, end_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              latch_vld_r, latch_vld_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.operation)
            OP_FILL:    if (fill_go) state_nxt = ST_FILL;
            OP_REFRESH: state_nxt = (eff_count == '0) ? ST_LATCH : ST_READ;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_FILL:  if (idx_r == end_r) state_nxt = ST_IDLE;
      ST_READ:  if (idx_r == end_r) state_nxt = ST_LATCH;
      ST_LATCH: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Datapath next values; end_r holds the last index to walk
  always_comb begin
    idx_nxt       = idx_r;
    end_nxt       = end_r;
    word_nxt      = word_r;
    rd_vld_nxt    = 1'b0;
    latch_vld_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          word_nxt = in_word;
          if (in_data.operation == OP_REFRESH) begin
            idx_nxt = '0;
            end_nxt = eff_count - 1'b1;
          end else begin
            idx_nxt = in_data.first_index;
            end_nxt = fill_end;
          end
        end
      end
      ST_FILL: idx_nxt = idx_r + 1'b1;
      ST_READ: begin
        idx_nxt    = idx_r + 1'b1;
        rd_vld_nxt = 1'b1;
      end
      ST_LATCH: latch_vld_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      latch_vld_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      latch_vld_r <= latch_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    end_r  <= end_nxt;
    word_r <= word_nxt;
  end

  // Memory controls. Writes and reads never overlap: a refresh only starts
  // from idle, after every earlier write has landed.
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [WORD_W-1:0] mem_rdata;

  always_comb begin
    busy      = (state_r != ST_IDLE);
    mem_we    = 1'b0;
    mem_waddr = in_data.first_index;
    mem_wdata = in_word;
    mem_re    = 1'b0;
    case (state_r)
      ST_IDLE: mem_we = accept && (in_data.operation == OP_SET) && set_ok;
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = word_r;
      end
      ST_READ: mem_re = 1'b1;
      default: ;
    endcase
  end

  lsfb_mem #(
    .DEPTH  (NUM_LEDS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr[ADDR_W-1:0]),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr   (idx_r[ADDR_W-1:0]),
    .rdata_r (mem_rdata)
  );

  // Result transfer: LED chunk straight from the read register, or latch
  always_comb begin
    out_strobe          = rd_vld_r || latch_vld_r;
    out_data.out_byte3  = '0;
    out_data.last       = latch_vld_r;
    if (rd_vld_r) begin
      out_data.out_byte0  = mem_rdata[23:16];
      out_data.out_byte1  = mem_rdata[15:8];
      out_data.out_byte2  = mem_rdata[7:0];
      out_data.byte_count = BYTES_LED;
    end else begin
      out_data.out_byte0  = '0;
      out_data.out_byte1  = '0;
      out_data.out_byte2  = '0;
      out_data.byte_count = BYTES_LATCH;
    end
  end

endmodule

`default_nettype wire

// ===== sv/lsfb_mem.sv =====
// Pixel store: one write port, one read port, registered read data.
// Depends on lsfb_pkg for the word width.
`timescale 1ns / 1ps
`default_nettype none

module lsfb_mem #(
  parameter int DEPTH  = lsfb_pkg::NUM_LEDS_DEF,
  parameter int ADDR_W = 5
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [ADDR_W-1:0]           waddr,
  input  wire logic [lsfb_pkg::WORD_W-1:0] wdata,
  input  wire logic                        re,
  input  wire logic [ADDR_W-1:0]           raddr,
  output logic      [lsfb_pkg::WORD_W-1:0] rdata_r
);
  import lsfb_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire
